### hdl/spherical_boundary_force_assert.svh
// Assertion macros for the spherical boundary force RTL.
`ifndef SPHERICAL_BOUNDARY_FORCE_ASSERT_SVH
`define SPHERICAL_BOUNDARY_FORCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sbf_pkg.sv
// Shared constants and stage types of the spherical boundary force block.
package sbf_pkg;

	localparam int CW = 24;
	localparam int SQ_W = 2 * CW;
	localparam int REM_W = CW + 1;
	localparam int RAD_W = 15;
	localparam int K_W = 16;
	localparam int PROD_W = CW + K_W;
	localparam int NAXIS = 3;
	localparam int NCELL = CW;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(10240);
	localparam logic [RAD_W-1:0] RADIUS_LOW_EXCL = RAD_W'(256);
	localparam logic [RAD_W-1:0] RADIUS_HIGH_EXCL = RAD_W'(20480);
	localparam logic [K_W-1:0] STIFFNESS_RESET = K_W'(16384);

	localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] NEG_MAG_MAX = {1'b1, {(CW-1){1'b0}}};

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_STIFFNESS = 1'b1
	} reg_idx_t;

	// Payload handed along the square root cells.
	typedef struct packed {
		logic [SQ_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [CW-1:0] root;
		logic [NAXIS-1:0][CW-1:0] mag;
		logic [NAXIS-1:0] pos;
		logic active;
	} sqrt_stage_t;

	// Payload handed along the divider cells.
	typedef struct packed {
		logic [NAXIS-1:0][CW-1:0] rem;
		logic [NAXIS-1:0][CW-1:0] num_lo;
		logic [NAXIS-1:0][CW-1:0] quo;
		logic [CW-1:0] dvsr;
		logic [NAXIS-1:0] pos;
		logic active;
	} div_stage_t;

endpackage

### hdl/spherical_boundary_force.sv
// One beat per cycle while the pipeline advances; beats pass a 24-cell square root
// chain and a 24-cell divider chain, one bit per cell.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (arst_n low, asynchronous) empties the pipeline and loads radius 40 mm
// and stiffness 0.25; no clearing pass is needed.
`include "spherical_boundary_force_assert.svh"

module spherical_boundary_force (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [23:0] force_x,
	output logic signed [23:0] force_y,
	output logic signed [23:0] force_z,
	output logic        force_active
);

	localparam int CW = sbf_pkg::CW;
	localparam int NA = sbf_pkg::NAXIS;
	localparam int NC = sbf_pkg::NCELL;

	logic [sbf_pkg::RAD_W-1:0] radius_q;
	logic [sbf_pkg::K_W-1:0]   stiff_q;
	logic                      wr_en;
	sbf_pkg::reg_idx_t         wr_idx;
	logic [sbf_pkg::RAD_W-1:0] wr_radius;
	logic                      en;

	logic                      v_s1;
	logic [NA-1:0][CW-1:0]     mag_s1;
	logic [NA-1:0]             pos_s1;
	logic                      v_s2;
	logic [NA-1:0][sbf_pkg::SQ_W-1:0] sq_s2;
	logic [NA-1:0][CW-1:0]     mag_s2;
	logic [NA-1:0]             pos_s2;

	logic [NA-1:0][CW-1:0]     pos_in;
	logic [sbf_pkg::SQ_W-1:0]  dsq_sum;
	logic [2*sbf_pkg::RAD_W-1:0] r_sq;
	sbf_pkg::sqrt_stage_t      sq_start;

	logic                      sq_v [NC+1];
	sbf_pkg::sqrt_stage_t      sq_st [NC+1];

	logic                      v_s4;
	logic [CW-1:0]             m_s4;
	logic [CW-1:0]             d_s4;
	logic [NA-1:0][CW-1:0]     mag_s4;
	logic [NA-1:0]             pos_s4;
	logic                      act_s4;
	logic [CW-1:0]             pen;
	logic [sbf_pkg::PROD_W-1:0] kpen;

	sbf_pkg::div_stage_t       dv_start;
	logic [NA-1:0][sbf_pkg::SQ_W-1:0] num;
	logic                      dv_v [NC+1];
	sbf_pkg::div_stage_t       dv_st [NC+1];

	logic                      out_valid_q;
	logic [NA-1:0][CW-1:0]     frc_d;
	logic [NA-1:0][CW-1:0]     frc_q;
	logic                      act_q;
	logic [CW-1:0]             quo;

	// Configuration port: zero-wait writes; radius writes outside the open range are dropped.
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign wr_idx = sbf_pkg::reg_idx_t'(paddr[2]);
	assign wr_radius = pwdata[sbf_pkg::RAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= sbf_pkg::RADIUS_RESET;
			stiff_q <= sbf_pkg::STIFFNESS_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				sbf_pkg::REG_RADIUS: begin
					if (wr_radius > sbf_pkg::RADIUS_LOW_EXCL &&
					    wr_radius < sbf_pkg::RADIUS_HIGH_EXCL) begin
						radius_q <= wr_radius;
					end
				end
				sbf_pkg::REG_STIFFNESS: stiff_q <= pwdata[sbf_pkg::K_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (sbf_pkg::reg_idx_t'(paddr[2]))
			sbf_pkg::REG_RADIUS: prdata = 32'(radius_q);
			sbf_pkg::REG_STIFFNESS: prdata = 32'(stiff_q);
			default: prdata = '0;
		endcase
	end

	// The pipeline moves whenever the output register can take a beat.
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// Stage 1: magnitudes and signs of the coordinates.
	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				mag_s1[a] <= pos_in[a][CW-1] ? CW'(-pos_in[a]) : pos_in[a];
				pos_s1[a] <= !pos_in[a][CW-1] && (pos_in[a] != '0);
			end
		end
	end

	// Stage 2: squares of the magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				sq_s2[a] <= sbf_pkg::SQ_W'(mag_s1[a]) * sbf_pkg::SQ_W'(mag_s1[a]);
			end
			mag_s2 <= mag_s1;
			pos_s2 <= pos_s1;
		end
	end

	// Stage 3: squared distance and the outside-sphere test feed the root chain.
	assign dsq_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];
	assign r_sq = (2*sbf_pkg::RAD_W)'(radius_q) * (2*sbf_pkg::RAD_W)'(radius_q);

	always_comb begin
		sq_start.rad = dsq_sum;
		sq_start.rem = '0;
		sq_start.root = '0;
		sq_start.mag = mag_s2;
		sq_start.pos = pos_s2;
		sq_start.active = dsq_sum > sbf_pkg::SQ_W'(r_sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_st[0] <= sq_start;
		end
	end

	// Square root chain, one root bit per cell.
	for (genvar i = 0; i < NC; i++) begin : g_sqrt
		sbf_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sq_v[i]),
			.stage_in (sq_st[i]),
			.valid_out(sq_v[i+1]),
			.stage_out(sq_st[i+1])
		);
	end

	// Stage after the root: force magnitude m = k * (d - r) / 65536.
	assign pen = sq_st[NC].root - CW'(radius_q);
	assign kpen = sbf_pkg::PROD_W'(stiff_q) * sbf_pkg::PROD_W'(pen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			dv_v[0] <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[NC];
			dv_v[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= kpen[sbf_pkg::PROD_W-1 -: CW];
			d_s4 <= sq_st[NC].root;
			mag_s4 <= sq_st[NC].mag;
			pos_s4 <= sq_st[NC].pos;
			act_s4 <= sq_st[NC].active;
		end
	end

	// Numerators m * |p_i|; the high half is already below the distance.
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			num[a] = sbf_pkg::SQ_W'(m_s4) * sbf_pkg::SQ_W'(mag_s4[a]);
			dv_start.rem[a] = num[a][sbf_pkg::SQ_W-1 -: CW];
			dv_start.num_lo[a] = num[a][CW-1:0];
			dv_start.quo[a] = '0;
		end
		dv_start.dvsr = d_s4;
		dv_start.pos = pos_s4;
		dv_start.active = act_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_st[0] <= dv_start;
		end
	end

	// Divider chain, one quotient bit per cell on each axis.
	for (genvar i = 0; i < NC; i++) begin : g_div
		sbf_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (dv_v[i]),
			.stage_in (dv_st[i]),
			.valid_out(dv_v[i+1]),
			.stage_out(dv_st[i+1])
		);
	end

	// Saturate and point the force toward the origin.
	always_comb begin
		quo = '0;
		for (int a = 0; a < NA; a++) begin
			quo = dv_st[NC].quo[a];
			if (!dv_st[NC].active) begin
				frc_d[a] = '0;
			end else if (dv_st[NC].pos[a]) begin
				frc_d[a] = (quo > sbf_pkg::NEG_MAG_MAX) ? sbf_pkg::NEG_MAG_MAX : CW'(-quo);
			end else begin
				frc_d[a] = (quo > sbf_pkg::POS_MAX) ? sbf_pkg::POS_MAX : quo;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_v[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_q <= frc_d;
			act_q <= dv_st[NC].active;
		end
	end

	assign out_valid = out_valid_q;
	assign force_x = frc_q[0];
	assign force_y = frc_q[1];
	assign force_z = frc_q[2];
	assign force_active = act_q;

	// A beat leaving the divider chain always lands in the output register.
	`SBF_ASSERT_NEXT(a_chain_to_out, en && dv_v[NC], out_valid_q, "divider beat lost")
	// A result without force_active carries zero force.
	`SBF_ASSERT_IMP(a_idle_zero, out_valid_q && !act_q,
		frc_q[0] == '0 && frc_q[1] == '0 && frc_q[2] == '0, "force outside active case")
	// The radius register never leaves its legal range.
	`SBF_ASSERT_IMP(a_radius_range, 1'b1,
		radius_q > sbf_pkg::RADIUS_LOW_EXCL && radius_q < sbf_pkg::RADIUS_HIGH_EXCL,
		"radius out of range")

endmodule

### hdl/sbf_sqrt_cell.sv
// One step of the integer square root: takes two radicand bits, yields one root bit.
module sbf_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  sbf_pkg::sqrt_stage_t stage_in,
	output logic                valid_out,
	output sbf_pkg::sqrt_stage_t stage_out
);

	logic                   valid_q;
	sbf_pkg::sqrt_stage_t   stage_q;
	logic [sbf_pkg::REM_W+1:0] rem_shift;
	logic [sbf_pkg::REM_W+1:0] trial;
	logic                   take;
	sbf_pkg::sqrt_stage_t   stage_d;

	// Trial subtraction of (4*root + 1) from the shifted remainder.
	always_comb begin
		rem_shift = {stage_in.rem, stage_in.rad[sbf_pkg::SQ_W-1 -: 2]};
		trial = {1'b0, stage_in.root, 2'b01};
		take = (rem_shift >= trial);
		stage_d = stage_in;
		stage_d.rad = {stage_in.rad[sbf_pkg::SQ_W-3:0], 2'b00};
		stage_d.root = {stage_in.root[sbf_pkg::CW-2:0], take};
		if (take) begin
			stage_d.rem = sbf_pkg::REM_W'(rem_shift - trial);
		end else begin
			stage_d.rem = sbf_pkg::REM_W'(rem_shift);
		end
	end

	// Beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= stage_d;
		end
	end

	assign valid_out = valid_q;
	assign stage_out = stage_q;

endmodule

### hdl/sbf_div_cell.sv
// One restoring division step on all three axes: yields one quotient bit each.
module sbf_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  sbf_pkg::div_stage_t stage_in,
	output logic               valid_out,
	output sbf_pkg::div_stage_t stage_out
);

	logic                  valid_q;
	sbf_pkg::div_stage_t   stage_q;
	sbf_pkg::div_stage_t   stage_d;
	logic [sbf_pkg::CW:0]  rem_shift [sbf_pkg::NAXIS];
	logic [sbf_pkg::NAXIS-1:0] take;

	// Shift in the next numerator bit and subtract the distance where it fits.
	always_comb begin
		stage_d = stage_in;
		for (int a = 0; a < sbf_pkg::NAXIS; a++) begin
			rem_shift[a] = {stage_in.rem[a], stage_in.num_lo[a][sbf_pkg::CW-1]};
			take[a] = (rem_shift[a] >= {1'b0, stage_in.dvsr});
			stage_d.num_lo[a] = {stage_in.num_lo[a][sbf_pkg::CW-2:0], 1'b0};
			stage_d.quo[a] = {stage_in.quo[a][sbf_pkg::CW-2:0], take[a]};
			if (take[a]) begin
				stage_d.rem[a] = sbf_pkg::CW'(rem_shift[a] - {1'b0, stage_in.dvsr});
			end else begin
				stage_d.rem[a] = sbf_pkg::CW'(rem_shift[a]);
			end
		end
	end

	// Beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= stage_d;
		end
	end

	assign valid_out = valid_q;
	assign stage_out = stage_q;

endmodule
